// ----- sv/tarf_pkg.sv -----
// Shared types and constants for the timestamped audio ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package tarf_pkg;

	// Fixed field widths.
	localparam int TIME_W  = 48;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = 11;

	// Opcodes of an input word.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_PLAN  = 6'b000100,
		S_GAP   = 6'b001000,
		S_DATA  = 6'b010000,
		S_PAD   = 6'b100000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               wr;          // store the input chunk
		logic               req_latch;   // capture the read request time
		logic               setup;       // compute gap and stale counts
		logic               apply_skip;  // drop the stale chunks
		logic               advance;     // consume one stored chunk
		logic               emit;        // load the output register
		logic               emit_data;   // output word carries stored data
		logic               emit_fill;   // output word is silence
		logic               emit_last;   // final word of the item
		logic               emit_wr;     // output word is a write result
		logic [COUNT_W-1:0] n;           // remaining request count
		logic [COUNT_W-1:0] drop;        // dropped count for the output word
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic               out_free;    // output register can take a word
		logic               fill_zero;   // no chunk stored
		logic [COUNT_W-1:0] gap;         // silence words owed to an early read
	} status_t;

endpackage

`default_nettype wire

// ----- sv/tarf_req_if.sv -----
// Request channel: write or read words into the FIFO.
`timescale 1ns / 1ps
`default_nettype none

interface tarf_req_if
	import tarf_pkg::*;
#(
	parameter int CHUNK_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [CHUNK_BITS-1:0] chunk_in;
	logic [COUNT_W-1:0]    count;
	logic [TIME_W-1:0]     time_stamp;

	modport source (output valid, output opcode, output chunk_in, output count,
		output time_stamp, input ready);
	modport sink (input valid, input opcode, input chunk_in, input count,
		input time_stamp, output ready);
endinterface

`default_nettype wire

// ----- sv/tarf_rsp_if.sv -----
// Response channel: result words out of the FIFO.
`timescale 1ns / 1ps
`default_nettype none

interface tarf_rsp_if
	import tarf_pkg::*;
#(
	parameter int CHUNK_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [CHUNK_BITS-1:0] chunk_out;
	logic                  is_fill;
	logic                  last;
	logic                  overwritten;
	logic [COUNT_W-1:0]    dropped_count;

	modport source (output valid, output chunk_out, output is_fill, output last,
		output overwritten, output dropped_count, input ready);
	modport sink (input valid, input chunk_out, input is_fill, input last,
		input overwritten, input dropped_count, output ready);
endinterface

`default_nettype wire

// ----- sv/tarf_ctrl.sv -----
// Sequencer of the ring FIFO: accepts words and steps a read through its phases.
`timescale 1ns / 1ps
`default_nettype none

module tarf_ctrl
	import tarf_pkg::*;
#(
	parameter int MAX_READ = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic [COUNT_W-1:0] count,
	input  wire status_t            status,
	output cmd_t                    cmd
);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] n_q, n_d;
	logic [COUNT_W-1:0] g_q, g_d;
	logic [COUNT_W-1:0] drop_q, drop_d;
	logic [COUNT_W-1:0] n_clamp;

	// Requests above the largest read are cut to it.
	assign n_clamp = (count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : count;

	assign in_ready = (state_q == S_IDLE) && status.out_free;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		n_d     = n_q;
		g_d     = g_q;
		drop_d  = drop_q;
		cmd     = '0;
		cmd.n   = n_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (opcode == OP_WRITE) begin
						cmd.wr        = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_wr   = 1'b1;
						cmd.emit_last = 1'b1;
					end else if (n_clamp != '0) begin
						cmd.req_latch = 1'b1;
						n_d           = n_clamp;
						state_d       = S_SETUP;
					end
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_PLAN;
			end
			S_PLAN: begin
				cmd.apply_skip = 1'b1;
				g_d            = status.gap;
				n_d            = n_q - status.gap;
				state_d        = (status.gap != '0) ? S_GAP : S_DATA;
			end
			S_GAP: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_fill = 1'b1;
					cmd.emit_last = (g_q == COUNT_W'(1)) && (n_q == '0);
					g_d           = g_q - COUNT_W'(1);
					if (g_q == COUNT_W'(1)) begin
						state_d = (n_q == '0) ? S_IDLE : S_DATA;
					end
				end
			end
			S_DATA: begin
				if (status.fill_zero) begin
					drop_d  = n_q;
					state_d = S_PAD;
				end else if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.advance   = 1'b1;
					cmd.emit_last = (n_q == COUNT_W'(1));
					n_d           = n_q - COUNT_W'(1);
					if (n_q == COUNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_PAD: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_fill = 1'b1;
					cmd.emit_last = (n_q == COUNT_W'(1));
					cmd.drop      = (n_q == COUNT_W'(1)) ? drop_q : '0;
					n_d           = n_q - COUNT_W'(1);
					if (n_q == COUNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			g_q     <= '0;
			drop_q  <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			g_q     <= g_d;
			drop_q  <= drop_d;
		end
	end

	// A silence phase always has words left to send.
	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAP) |-> (g_q != '0))
		else $error("gap phase entered with no silence owed");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA || state_q == S_PAD) |-> (n_q != '0))
		else $error("data or pad phase with zero words remaining");

	a_pad_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD) |-> (n_q <= drop_q))
		else $error("pad count exceeds the dropped total");

endmodule

`default_nettype wire

// ----- sv/tarf_dp.sv -----
// Datapath of the ring FIFO: chunk memory, pointers, fill level, read time, output register.
`timescale 1ns / 1ps
`default_nettype none

module tarf_dp
	import tarf_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int CHUNK_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [CHUNK_BITS-1:0] chunk_in,
	input  wire logic [TIME_W-1:0]     time_stamp,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [CHUNK_BITS-1:0]      chunk_out,
	output logic                       is_fill,
	output logic                       last,
	output logic                       overwritten,
	output logic [COUNT_W-1:0]         dropped_count
);

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = PW + 1;

	logic [CHUNK_BITS-1:0] chunk_store_q [DEPTH];
	logic [CHUNK_BITS-1:0] rd_data_q;
	logic [PW-1:0]         rp_q, rp_d, wp_q, wp_d;
	logic [FW-1:0]         fill_q, fill_d, cap_q, cap_d;
	logic [TIME_W-1:0]     rt_q, rt_d, ts_q;
	logic [FW-1:0]         skip_q;
	logic [COUNT_W-1:0]    gap_q;
	logic                  full;
	logic [AW-1:0]         cap_ext, wp_inc, rp_inc, skip_sum, skip_wrap;
	logic [PW-1:0]         wp_adv, rp_adv;
	logic [TIME_W-1:0]     e_diff, l_diff;
	logic                  early, late, gap_lt, skip_lt;
	logic                  out_valid_q;

	assign cap_ext = AW'(cap_q);
	assign full    = (fill_q >= cap_q);

	// Pointer advance by one, modulo the capacity in use.
	assign wp_inc = AW'(wp_q) + AW'(1);
	assign rp_inc = AW'(rp_q) + AW'(1);
	assign wp_adv = (wp_inc == cap_ext) ? '0 : wp_inc[PW-1:0];
	assign rp_adv = (rp_inc == cap_ext) ? '0 : rp_inc[PW-1:0];

	// Skip past stale chunks; the sum stays below twice the capacity.
	assign skip_sum  = AW'(rp_q) + AW'(skip_q);
	assign skip_wrap = (skip_sum >= cap_ext) ? (skip_sum - cap_ext) : skip_sum;

	// Time comparison of the request against the read time.
	assign e_diff  = rt_q - ts_q;
	assign l_diff  = ts_q - rt_q;
	assign early   = (rt_q > ts_q);
	assign late    = (ts_q > rt_q);
	assign gap_lt  = (e_diff[TIME_W-1:COUNT_W] == '0) && (e_diff[COUNT_W-1:0] < cmd.n);
	assign skip_lt = (l_diff[TIME_W-1:FW] == '0) && (l_diff[FW-1:0] < fill_q);

	// Capacity write, clamped to the legal range.
	always_comb begin
		if (cfg_data == '0) begin
			cap_d = FW'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cap_d = FW'(DEPTH);
		end else begin
			cap_d = FW'(cfg_data);
		end
	end

	// Next values of the ring state.
	always_comb begin
		rp_d   = rp_q;
		wp_d   = wp_q;
		fill_d = fill_q;
		rt_d   = rt_q;
		if (cfg_we) begin
			rp_d   = '0;
			wp_d   = '0;
			fill_d = '0;
		end else if (cmd.wr) begin
			wp_d = wp_adv;
			if (fill_q == '0) begin
				rt_d = time_stamp;
			end
			if (full) begin
				rp_d = wp_adv;
			end else begin
				fill_d = fill_q + FW'(1);
			end
		end else if (cmd.apply_skip) begin
			rp_d   = skip_wrap[PW-1:0];
			fill_d = fill_q - skip_q;
			rt_d   = rt_q + TIME_W'(skip_q);
		end else if (cmd.advance) begin
			rp_d   = rp_adv;
			fill_d = fill_q - FW'(1);
			rt_d   = rt_q + TIME_W'(1);
		end
	end

	// Ring control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			rt_q   <= '0;
			cap_q  <= FW'(DEPTH);
		end else begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			fill_q <= fill_d;
			rt_q   <= rt_d;
			if (cfg_we) begin
				cap_q <= cap_d;
			end
		end
	end

	// Chunk memory; the read follows the next read pointer, new data bypasses.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			chunk_store_q[wp_q] <= chunk_in;
		end
		if (cmd.wr && (wp_q == rp_d)) begin
			rd_data_q <= chunk_in;
		end else begin
			rd_data_q <= chunk_store_q[rp_d];
		end
	end

	// Request time and the gap and stale counts of a read.
	always_ff @(posedge clk) begin
		if (cmd.req_latch) begin
			ts_q <= time_stamp;
		end
		if (cmd.setup) begin
			if (early && (fill_q != '0)) begin
				gap_q <= gap_lt ? e_diff[COUNT_W-1:0] : cmd.n;
			end else begin
				gap_q <= '0;
			end
			if (late) begin
				skip_q <= skip_lt ? l_diff[FW-1:0] : fill_q;
			end else begin
				skip_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			chunk_out     <= cmd.emit_data ? rd_data_q : '0;
			is_fill       <= cmd.emit_fill;
			last          <= cmd.emit_last;
			overwritten   <= cmd.emit_wr && full;
			dropped_count <= cmd.drop;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.fill_zero = (fill_q == '0);
	assign status.gap       = gap_q;

	// Ring invariants.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill level above capacity");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW'(rp_q) < cap_ext) && (AW'(wp_q) < cap_ext))
		else $error("pointer outside the capacity in use");

	a_empty_full_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		((fill_q == '0) || (fill_q == cap_q)) |-> (rp_q == wp_q))
		else $error("pointers disagree on an empty or full ring");

endmodule

`default_nettype wire

// ----- sv/timestamped_audio_ring_fifo.sv -----
// Top level of the timestamped audio ring FIFO.
// Ring FIFO of audio chunks that overwrites the oldest chunk when full and
// tracks the sample time of the next chunk to be read. A write word stores
// one chunk and returns one result, so writes flow at one per cycle while
// results are taken. A read word with count n (capped at MAX_READ) compares
// its time against the read time and drops stale chunks in its setup and
// plan states, then returns its n results at one per cycle while results are
// taken, from a registered memory read; where stored data runs out, the
// sequencer moves to its pad state before silence padding begins. Every
// result passes through an output register, and a new word is taken only
// when that register is empty or its word is taken in the same cycle.
// Writing the capacity empties the FIFO at once and keeps the read time.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_audio_ring_fifo
	import tarf_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int CHUNK_BITS = 32,
	parameter int MAX_READ   = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data,
	tarf_req_if.sink              req,
	tarf_rsp_if.source            rsp
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	tarf_ctrl #(
		.MAX_READ (MAX_READ)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.opcode   (req.opcode),
		.count    (req.count),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage and output register.
	tarf_dp #(
		.DEPTH      (DEPTH),
		.CHUNK_BITS (CHUNK_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.chunk_in      (req.chunk_in),
		.time_stamp    (req.time_stamp),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.chunk_out     (rsp.chunk_out),
		.is_fill       (rsp.is_fill),
		.last          (rsp.last),
		.overwritten   (rsp.overwritten),
		.dropped_count (rsp.dropped_count)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_timestamped_audio_ring_fifo.sv -----
// Self-checking testbench for the timestamped audio ring FIFO, with its own predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_timestamped_audio_ring_fifo;
	import tarf_pkg::*;

	localparam int RING_DEPTH   = 1024;
	localparam int CHUNK_W      = 32;
	localparam int MAX_READ     = 64;
	localparam int PHASE_WORDS  = 45;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

	// How the time stamp of a queued word is formed when it goes on the bus.
	typedef enum bit {
		TS_FIXED,
		TS_FROM_READ
	} ts_mode_t;

	typedef struct {
		logic               opcode;
		logic [CHUNK_W-1:0] chunk;
		logic [COUNT_W-1:0] count;
		ts_mode_t           mode;
		logic [TIME_W-1:0]  ts;
	} req_word_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic               is_fill;
		logic               last;
		logic               overwritten;
		logic [COUNT_W-1:0] dropped;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_data;

	tarf_req_if #(.CHUNK_BITS(CHUNK_W)) req_ch ();
	tarf_rsp_if #(.CHUNK_BITS(CHUNK_W)) rsp_ch ();

	timestamped_audio_ring_fifo #(
		.DEPTH(RING_DEPTH),
		.CHUNK_BITS(CHUNK_W),
		.MAX_READ(MAX_READ)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the ring and its pointers.
	logic [CHUNK_W-1:0] shadow_ring [RING_DEPTH];
	int unsigned        ring_rd;
	int unsigned        ring_wr;
	int unsigned        ring_level;
	int unsigned        ring_cap;
	logic [TIME_W-1:0]  ring_time;

	req_word_t    queued_words [$];
	result_word_t due_results [$];
	int unsigned  mismatches = 0;
	bit           offering;

	function automatic void ring_set_capacity(input logic [CFG_W-1:0] v);
		if (v == 0)
			ring_cap = 1;
		else if (v > RING_DEPTH)
			ring_cap = RING_DEPTH;
		else
			ring_cap = 32'(v);
		ring_rd = 0;
		ring_wr = 0;
		ring_level = 0;
	endfunction

	function automatic int unsigned ring_next(input int unsigned p, input int unsigned by);
		return (p + by) % ring_cap;
	endfunction

	function automatic void push_result(input logic [CHUNK_W-1:0] chunk, input logic fill,
			input logic last, input logic ovw, input logic [COUNT_W-1:0] drop);
		result_word_t r;
		r = {chunk, fill, last, ovw, drop};
		due_results.push_back(r);
	endfunction

	// Works out the result words of one accepted word and updates the shadow state.
	function automatic void ring_apply(input req_word_t w);
		int unsigned n, g, r, m, drop, i;
		logic [TIME_W-1:0] span;
		if (w.opcode == OP_WRITE) begin
			if (ring_level == 0)
				ring_time = w.ts;
			shadow_ring[ring_wr] = w.chunk;
			ring_wr = ring_next(ring_wr, 1);
			if (ring_level >= ring_cap) begin
				ring_rd = ring_wr;
				ring_level = ring_cap;
				push_result('0, 1'b0, 1'b1, 1'b1, '0);
			end else begin
				ring_level++;
				push_result('0, 1'b0, 1'b1, 1'b0, '0);
			end
			return;
		end
		n = (w.count > MAX_READ) ? MAX_READ : w.count;
		if (n == 0)
			return;
		// An empty FIFO answers with silence only.
		if (ring_level == 0) begin
			for (i = 0; i < n; i++)
				push_result('0, 1'b1, i + 1 == n, 1'b0,
					(i + 1 == n) ? COUNT_W'(n) : COUNT_W'(0));
			return;
		end
		if (ring_time > w.ts) begin
			// Early request: silence covers the gap first.
			span = ring_time - w.ts;
			g = (span < n) ? span[31:0] : n;
			for (i = 0; i < g; i++)
				push_result('0, 1'b1, i + 1 == n, 1'b0, '0);
			if (g == n)
				return;
			n -= g;
		end else if (w.ts > ring_time) begin
			// Late request: stale chunks are thrown away.
			span = w.ts - ring_time;
			r = (span < ring_level) ? span[31:0] : ring_level;
			ring_rd = ring_next(ring_rd, r);
			ring_level -= r;
			ring_time = ring_time + r;
		end
		m = (n < ring_level) ? n : ring_level;
		drop = n - m;
		ring_time = ring_time + m;
		for (i = 0; i < m; i++) begin
			push_result(shadow_ring[ring_rd], 1'b0, drop == 0 && i + 1 == m, 1'b0, '0);
			ring_rd = ring_next(ring_rd, 1);
		end
		ring_level -= m;
		for (i = 0; i < drop; i++)
			push_result('0, 1'b1, i + 1 == drop, 1'b0,
				(i + 1 == drop) ? COUNT_W'(drop) : COUNT_W'(0));
	endfunction

	function automatic void queue_word(input logic op, input logic [CHUNK_W-1:0] chunk,
			input logic [COUNT_W-1:0] count, input ts_mode_t mode, input logic [TIME_W-1:0] ts);
		req_word_t w;
		w = '{op, chunk, count, mode, ts};
		queued_words.push_back(w);
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// Signed offset from the read time, as a 48-bit two's complement value.
	function automatic logic [TIME_W-1:0] time_offset(input int off);
		return {{(TIME_W - 32){off[31]}}, off};
	endfunction

	// Mostly short gaps, a few long ones, and now and then a run with none.
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit fifo_busy();
		return queued_words.size() != 0 || offering || due_results.size() != 0;
	endfunction

	// Bursts of writes followed by reads near the read time, with some noise reads.
	task automatic queue_random_words(input int unsigned total);
		int unsigned made, burst, reads, k, sel;
		int off;
		logic [COUNT_W-1:0] cnt;
		made = 0;
		while (made < total) begin
			burst = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(8, 24);
			for (k = 0; k < burst; k++) begin
				if ($urandom_range(0, 99) < 30)
					queue_word(OP_WRITE, $urandom, COUNT_W'($urandom), TS_FIXED, random_time());
				else
					queue_word(OP_WRITE, $urandom, COUNT_W'($urandom), TS_FROM_READ,
						time_offset(int'($urandom_range(0, 6)) - 3));
			end
			reads = $urandom_range(1, 3);
			for (k = 0; k < reads; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 70)
					cnt = COUNT_W'($urandom_range(1, 8));
				else if (sel < 90)
					cnt = COUNT_W'($urandom_range(9, 64));
				else if (sel < 95)
					cnt = '0;
				else
					cnt = COUNT_W'($urandom_range(65, 127));
				sel = $urandom_range(0, 99);
				if (sel < 75) begin
					queue_word(OP_READ, $urandom, cnt, TS_FROM_READ,
						time_offset(int'($urandom_range(0, 12)) - 6));
				end else if (sel < 88) begin
					off = $urandom_range(20, 200);
					queue_word(OP_READ, $urandom, cnt, TS_FROM_READ,
						time_offset($urandom_range(0, 1) ? off : -off));
				end else begin
					queue_word(OP_READ, $urandom, cnt, TS_FIXED, random_time());
				end
			end
			made += burst + reads;
		end
	endtask

	// Request driver: offers queued words with random gaps and predicts on acceptance.
	int unsigned req_gap;
	int unsigned req_calm;
	req_word_t   live_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= OP_WRITE;
			req_ch.chunk_in <= '0;
			req_ch.count <= '0;
			req_ch.time_stamp <= '0;
			offering = 1'b0;
			req_gap = 0;
			req_calm = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				ring_apply(live_word);
				offering = 1'b0;
				req_gap = pick_gap(req_calm);
			end
			if (!offering) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (queued_words.size() != 0) begin
					live_word = queued_words.pop_front();
					if (live_word.mode == TS_FROM_READ)
						live_word.ts = ring_time + live_word.ts;
					req_ch.opcode <= live_word.opcode;
					req_ch.chunk_in <= live_word.chunk;
					req_ch.count <= live_word.count;
					req_ch.time_stamp <= live_word.ts;
					offering = 1'b1;
				end
			end
			req_ch.valid <= offering;
		end
	end

	// One long receiver hold-off after the stream is under way, so the input stalls.
	int unsigned hold_seen;
	int unsigned hold_left;
	bit          hold_done;
	logic        rsp_hold;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
			rsp_hold <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				hold_seen++;
			if (!hold_done && hold_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_hold <= (hold_left > 0);
		end
	end

	// Result monitor: checks each accepted word against the oldest expected one.
	int unsigned  rsp_gap;
	int unsigned  rsp_calm;
	result_word_t got;
	result_word_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_gap = 0;
			rsp_calm = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.chunk_out, rsp_ch.is_fill, rsp_ch.last, rsp_ch.overwritten,
					rsp_ch.dropped_count};
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: chunk=%h fill=%b last=%b ovw=%b drop=%0d",
							got.chunk, got.is_fill, got.last, got.overwritten, got.dropped);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected chunk=%h fill=%b last=%b ",
								"ovw=%b drop=%0d, got chunk=%h fill=%b last=%b ovw=%b drop=%0d"},
								want.chunk, want.is_fill, want.last, want.overwritten,
								want.dropped, got.chunk, got.is_fill, got.last,
								got.overwritten, got.dropped);
					end
				end
				rsp_gap = pick_gap(rsp_calm);
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !rsp_hold;
			end
		end
	end

	// Stimulus sequence: directed words, then capacity phases with random traffic.
	initial begin
		logic [CFG_W-1:0] caps [$];
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_WRITE;
		req_ch.chunk_in = '0;
		req_ch.count = '0;
		req_ch.time_stamp = '0;
		rsp_ch.ready = 1'b0;
		ring_set_capacity(RING_DEPTH);
		ring_time = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads on an empty FIFO, including a zero count.
		queue_word(OP_READ, '0, 3, TS_FIXED, '0);
		queue_word(OP_READ, '1, 0, TS_FIXED, MAX_TIME);
		// First write sets the read time close to the top of the time range.
		queue_word(OP_WRITE, '1, '0, TS_FIXED, MAX_TIME - 1);
		queue_word(OP_WRITE, '0, '1, TS_FIXED, '0);
		queue_word(OP_WRITE, 32'hA5A5_A5A5, '0, TS_FROM_READ, '0);
		queue_word(OP_READ, '0, 1, TS_FROM_READ, '0);
		// Early by two: silence, then the stored chunks; the read time wraps.
		queue_word(OP_READ, '0, 4, TS_FROM_READ, time_offset(-2));
		queue_word(OP_WRITE, 32'h0000_0001, '0, TS_FIXED, 100);
		queue_word(OP_WRITE, 32'h0000_0002, '0, TS_FIXED, 100);
		queue_word(OP_WRITE, 32'h0000_0003, '0, TS_FIXED, 100);
		// Late by two: stale chunks skipped, shortfall padded.
		queue_word(OP_READ, '0, 5, TS_FROM_READ, time_offset(2));
		queue_word(OP_WRITE, 32'h1234_5678, '0, TS_FIXED, 1000);
		queue_word(OP_WRITE, 32'h8765_4321, '0, TS_FIXED, 1000);
		// Gap longer than the request: silence only, nothing dropped.
		queue_word(OP_READ, '0, 3, TS_FROM_READ, time_offset(-10));
		// Oversized count far in the future drains everything.
		queue_word(OP_READ, '0, 127, TS_FIXED, MAX_TIME);
		queue_word(OP_READ, '0, 64, TS_FIXED, '0);
		queue_word(OP_READ, '0, 65, TS_FROM_READ, '0);
		queue_word(OP_WRITE, 32'h5A5A_5A5A, '0, TS_FIXED, '0);
		queue_word(OP_READ, '0, 1, TS_FROM_READ, '0);

		caps = '{11'd1, 11'd0, 11'd2, 11'd5, 11'd2047, CFG_W'($urandom_range(3, 40)),
			11'd16, 11'd1025, 11'd1024};
		foreach (caps[p]) begin
			while (fifo_busy())
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_data <= caps[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			ring_set_capacity(caps[p]);
			queue_random_words(PHASE_WORDS);
		end

		while (fifo_busy())
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += due_results.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
